// File: rtl/core/gsrt_pkg.sv
// shared types, constants and codes of the gate slot reservation table
`timescale 1ns / 1ps
package gsrt_pkg;

   localparam int GATES_DEFAULT = 8;
   localparam int SLOTS_DEFAULT = 48;
   localparam logic [3:0] GATES_RESET = 4'd8;
   localparam logic [7:0] NODE_RESET  = 8'd0;
   localparam int ENTRY_W = 29;

   // actions
   localparam logic [1:0] ACT_RESERVE = 2'd0;
   localparam logic [1:0] ACT_LOOKUP  = 2'd1;
   localparam logic [1:0] ACT_STATUS  = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MISS      = 3'd1;
   localparam logic [2:0] ST_WRONG_NODE = 3'd2;
   localparam logic [2:0] ST_BAD_START = 3'd3;
   localparam logic [2:0] ST_BAD_SPAN  = 3'd4;
   localparam logic [2:0] ST_BAD_GATE  = 3'd5;

   // register indexes
   localparam logic REG_GATES = 1'b0;
   localparam logic REG_NODE  = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP, DP_CLEAR, DP_LOAD, DP_GATE_FIRST, DP_RES_START, DP_NEXT_GATE, DP_RD,
      DP_RES_SKIP, DP_INC, DP_RES_FOUND, DP_RES_WRITE, DP_LK_START, DP_LK_JUMP,
      DP_ST_START
   } dp_op_type;

   typedef enum logic [2:0] {
      EM_NONE, EM_ERR, EM_RES_OK, EM_LK_OK, EM_SLOT
   } emit_type;

   typedef struct packed {
      dp_op_type  op;
      emit_type   emit;
      logic [2:0] code;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic [1:0] action;
      logic [2:0] err_code;
      logic       gate_end;
      logic       slot_end;
      logic       occ;
      logic       own_match;
      logic       slack_end;
      logic       run_done;
      logic       wr_done;
      logic       out_free;
   } sts_type;

endpackage

// File: rtl/core/gate_slot_reservation_table_core.sv
// top level of the gate slot reservation table
`timescale 1ns / 1ps
// gate slot reservation table
// req_ channel: one item per request (reserve, lookup owner, slot status); action 3 is
//   taken and dropped without a result
// rsp_ channel: one result item per request, or span+1 items for a slot status report;
//   rsp_last marks the final item of a request
// csr_ channel: index 0 gates_in_use, index 1 node_id; always ready; the user is to
//   write it only while idle, which the block itself leaves unchecked
// search: a request reads the slot memory one slot at a time (address, then registered
//   data); reserve and lookup go on gate by gate, and reserve then writes its booked
//   slots one at a time; a status report gives one item per slot read; an error goes
//   from the check state through the error state to the result register
// throughput: one request at a time; a new item is taken once the previous request has
//   issued its final result, even while that result still waits in the output register
// reset: synchronous; registers return to gates_in_use 8, node_id 0, and a clearing pass
//   writes each of the 2**(GW+6) memory words to zero, one per cycle, GW being
//   clog2(MAX_GATES) but at least 1 (512 words by default); meanwhile no item is accepted
// stall: when rsp_ready is low the held result stays put and the search waits at its
//   next result
module gate_slot_reservation_table_core #(
   parameter int MAX_GATES      = gsrt_pkg::GATES_DEFAULT,
   parameter int SLOTS_PER_GATE = gsrt_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_target_node,
   input  logic [15:0] req_owner_id,
   input  logic [5:0]  req_first_slot,
   input  logic [5:0]  req_span,
   input  logic [5:0]  req_slack,
   input  logic [2:0]  req_gate_sel,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_gate,
   output logic [5:0]  rsp_start_slot,
   output logic [5:0]  rsp_end_slot,
   output logic [5:0]  rsp_slot_index,
   output logic        rsp_occupied,
   output logic [15:0] rsp_owner,
   output logic        rsp_last
);
   import gsrt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   // sequencing of searches, writes and result hand-off
   gsrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot memory, counters, request and result registers
   gsrt_dp #(
      .MAX_GATES      (MAX_GATES),
      .SLOTS_PER_GATE (SLOTS_PER_GATE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_target_node (req_target_node),
      .req_owner_id    (req_owner_id),
      .req_first_slot  (req_first_slot),
      .req_span        (req_span),
      .req_slack       (req_slack),
      .req_gate_sel    (req_gate_sel),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_gate        (rsp_gate),
      .rsp_start_slot  (rsp_start_slot),
      .rsp_end_slot    (rsp_end_slot),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_occupied    (rsp_occupied),
      .rsp_owner       (rsp_owner),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/core/gsrt_ctrl.sv
// controller state machine of the gate slot reservation table
`timescale 1ns / 1ps
module gsrt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gsrt_pkg::sts_type sts,
   output gsrt_pkg::cmd_type cmd
);
   import gsrt_pkg::*;

   typedef enum logic [13:0] {
      S_CLEAR   = 14'b00000000000001,
      S_IDLE    = 14'b00000000000010,
      S_CHECK   = 14'b00000000000100,
      S_RES_GATE = 14'b00000000001000,
      S_RES_RD  = 14'b00000000010000,
      S_RES_EV  = 14'b00000000100000,
      S_RES_WR  = 14'b00000001000000,
      S_LK_GATE = 14'b00000010000000,
      S_LK_RD   = 14'b00000100000000,
      S_LK_EV   = 14'b00001000000000,
      S_ST_RD   = 14'b00010000000000,
      S_ST_EV   = 14'b00100000000000,
      S_ERR     = 14'b01000000000000,
      S_MISS    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      cmd.emit = EM_NONE;
      cmd.code = ST_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.action == ACT_NONE) begin
               state_in = S_IDLE;
            end else if (sts.err_code != ST_OK) begin
               state_in = S_ERR;
            end else if (sts.action == ACT_RESERVE) begin
               cmd.op   = DP_GATE_FIRST;
               state_in = S_RES_GATE;
            end else if (sts.action == ACT_LOOKUP) begin
               cmd.op   = DP_GATE_FIRST;
               state_in = S_LK_GATE;
            end else begin
               cmd.op   = DP_ST_START;
               state_in = S_ST_RD;
            end
         end
         S_RES_GATE: begin
            if (sts.gate_end) begin
               state_in = S_MISS;
            end else begin
               cmd.op   = DP_RES_START;
               state_in = S_RES_RD;
            end
         end
         S_RES_RD: begin
            if (sts.slot_end) begin
               cmd.op   = DP_NEXT_GATE;
               state_in = S_RES_GATE;
            end else begin
               cmd.op   = DP_RD;
               state_in = S_RES_EV;
            end
         end
         S_RES_EV: begin
            if (sts.occ) begin
               if (sts.slack_end) begin
                  cmd.op   = DP_NEXT_GATE;
                  state_in = S_RES_GATE;
               end else begin
                  cmd.op   = DP_RES_SKIP;
                  state_in = S_RES_RD;
               end
            end else if (sts.run_done) begin
               cmd.op   = DP_RES_FOUND;
               state_in = S_RES_WR;
            end else begin
               cmd.op   = DP_INC;
               state_in = S_RES_RD;
            end
         end
         S_RES_WR: begin
            if (!sts.wr_done) begin
               cmd.op = DP_RES_WRITE;
            end else if (sts.out_free) begin
               cmd.op   = DP_RES_WRITE;
               cmd.emit = EM_RES_OK;
               state_in = S_IDLE;
            end
         end
         S_LK_GATE: begin
            if (sts.gate_end) begin
               state_in = S_MISS;
            end else begin
               cmd.op   = DP_LK_START;
               state_in = S_LK_RD;
            end
         end
         S_LK_RD: begin
            if (sts.slot_end) begin
               cmd.op   = DP_NEXT_GATE;
               state_in = S_LK_GATE;
            end else begin
               cmd.op   = DP_RD;
               state_in = S_LK_EV;
            end
         end
         S_LK_EV: begin
            if (!sts.occ) begin
               cmd.op   = DP_INC;
               state_in = S_LK_RD;
            end else if (sts.own_match) begin
               if (sts.out_free) begin
                  cmd.emit = EM_LK_OK;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.op   = DP_LK_JUMP;
               state_in = S_LK_RD;
            end
         end
         S_ST_RD: begin
            cmd.op   = DP_RD;
            state_in = S_ST_EV;
         end
         S_ST_EV: begin
            if (sts.out_free) begin
               cmd.op   = DP_INC;
               cmd.emit = EM_SLOT;
               state_in = sts.wr_done ? S_IDLE : S_ST_RD;
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit = EM_ERR;
               cmd.code = sts.err_code;
               state_in = S_IDLE;
            end
         end
         S_MISS: begin
            if (sts.out_free) begin
               cmd.emit = EM_ERR;
               cmd.code = ST_MISS;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// File: rtl/core/gsrt_dp.sv
// datapath of the gate slot reservation table: slot memory, counters, result register
`timescale 1ns / 1ps
module gsrt_dp #(
   parameter int MAX_GATES      = gsrt_pkg::GATES_DEFAULT,
   parameter int SLOTS_PER_GATE = gsrt_pkg::SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  gsrt_pkg::cmd_type cmd,
   output gsrt_pkg::sts_type sts,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_target_node,
   input  logic [15:0]       req_owner_id,
   input  logic [5:0]        req_first_slot,
   input  logic [5:0]        req_span,
   input  logic [5:0]        req_slack,
   input  logic [2:0]        req_gate_sel,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [7:0]        csr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [2:0]        rsp_gate,
   output logic [5:0]        rsp_start_slot,
   output logic [5:0]        rsp_end_slot,
   output logic [5:0]        rsp_slot_index,
   output logic              rsp_occupied,
   output logic [15:0]       rsp_owner,
   output logic              rsp_last
);
   import gsrt_pkg::*;

   localparam int GW  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
   localparam int GCW = $clog2(MAX_GATES + 1);
   localparam int AW  = GW + 6;
   localparam int DEPTH = 1 << AW;

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [1:0]  act_ff;
   logic [7:0]  tn_ff;
   logic [15:0] own_ff;
   logic [5:0]  first_ff, span_ff, slack_ff;
   logic [2:0]  gsel_ff;
   logic [3:0]  gates_ff;
   logic [7:0]  node_ff;
   logic [GCW-1:0] g_ff, g_in;
   logic [6:0]  i_ff, i_in, s_ff, s_in, e_ff, e_in;
   logic [AW-1:0] clr_ff;
   logic [ENTRY_W-1:0] rd_ff;
   logic        rsp_valid_ff;

   logic [7:0]  ng8;
   logic [AW-1:0] addr;
   logic        rd_occ;
   logic [15:0] rd_owner;
   logic [5:0]  rd_last;
   logic [6:0]  nx;
   logic [GCW+2:0] g_ext;
   logic        wr_en;
   logic [ENTRY_W-1:0] wr_data;

   assign ng8 = ({4'd0, gates_ff} > 8'(MAX_GATES)) ? 8'(MAX_GATES) : {4'd0, gates_ff};
   assign addr = (cmd.op == DP_CLEAR) ? clr_ff : {g_ff[GW-1:0], i_ff[5:0]};
   assign rd_occ   = rd_ff[28];
   assign rd_owner = rd_ff[27:12];
   assign rd_last  = rd_ff[5:0];
   assign nx = {1'b0, rd_last} + 7'd1;
   assign g_ext = {3'd0, g_ff};
   assign wr_en = (cmd.op == DP_CLEAR) || (cmd.op == DP_RES_WRITE);
   assign wr_data = (cmd.op == DP_CLEAR) ? '0 : {1'b1, own_ff, s_ff[5:0], e_ff[5:0]};

   // status towards the controller
   always_comb begin
      sts.clr_last = (clr_ff == '1);
      sts.action   = act_ff;
      sts.err_code = ST_OK;
      if (tn_ff != node_ff) begin
         sts.err_code = ST_WRONG_NODE;
      end else if (act_ff == ACT_RESERVE) begin
         if ({1'b0, first_ff} >= 7'(SLOTS_PER_GATE))
            sts.err_code = ST_BAD_START;
         else if ({1'b0, first_ff} + {1'b0, span_ff} > 7'(SLOTS_PER_GATE))
            sts.err_code = ST_BAD_SPAN;
      end else if (act_ff == ACT_STATUS) begin
         if ({5'd0, gsel_ff} >= ng8)
            sts.err_code = ST_BAD_GATE;
         else if ({1'b0, first_ff} >= 7'(SLOTS_PER_GATE))
            sts.err_code = ST_BAD_START;
         else if ({1'b0, first_ff} + {1'b0, span_ff} >= 7'(SLOTS_PER_GATE))
            sts.err_code = ST_BAD_SPAN;
      end
      sts.gate_end  = (8'(g_ff) >= ng8);
      sts.slot_end  = (i_ff >= 7'(SLOTS_PER_GATE));
      sts.occ       = rd_occ;
      sts.own_match = (rd_owner == own_ff);
      sts.slack_end = ({1'b0, i_ff} >= {2'd0, first_ff} + {2'd0, slack_ff});
      sts.run_done  = ({1'b0, i_ff} == {1'b0, s_ff} + {2'd0, span_ff});
      sts.wr_done   = (i_ff == e_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // counters
   always_comb begin
      g_in = g_ff;
      i_in = i_ff;
      s_in = s_ff;
      e_in = e_ff;
      case (cmd.op)
         DP_GATE_FIRST: g_in = '0;
         DP_NEXT_GATE:  g_in = g_ff + GCW'(1);
         DP_RES_START: begin
            i_in = {1'b0, first_ff};
            s_in = {1'b0, first_ff};
         end
         DP_RES_SKIP: begin
            i_in = i_ff + 7'd1;
            s_in = i_ff + 7'd1;
         end
         DP_INC, DP_RES_WRITE: i_in = i_ff + 7'd1;
         DP_RES_FOUND: begin
            i_in = s_ff;
            e_in = i_ff;
         end
         DP_LK_START: i_in = '0;
         DP_LK_JUMP:  i_in = (nx > i_ff) ? nx : i_ff + 7'd1;
         DP_ST_START: begin
            g_in = GCW'(gsel_ff);
            i_in = {1'b0, first_ff};
            e_in = {1'b0, first_ff} + {1'b0, span_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
      i_ff <= i_in;
      s_ff <= s_in;
      e_ff <= e_in;
      if (cmd.op == DP_LOAD) begin
         act_ff   <= req_action;
         tn_ff    <= req_target_node;
         own_ff   <= req_owner_id;
         first_ff <= req_first_slot;
         span_ff  <= req_span;
         slack_ff <= req_slack;
         gsel_ff  <= req_gate_sel;
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      if (cmd.op == DP_RD) rd_ff <= mem[addr];
   end

   // clearing pass counter and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         gates_ff <= GATES_RESET;
         node_ff  <= NODE_RESET;
      end else begin
         if (cmd.op == DP_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_valid) begin
            if (csr_index == REG_GATES) gates_ff <= csr_data[3:0];
            else                        node_ff  <= csr_data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EM_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != EM_NONE) begin
         rsp_status     <= ST_OK;
         rsp_gate       <= '0;
         rsp_start_slot <= '0;
         rsp_end_slot   <= '0;
         rsp_slot_index <= '0;
         rsp_occupied   <= 1'b0;
         rsp_owner      <= '0;
         rsp_last       <= 1'b1;
         case (cmd.emit)
            EM_ERR: rsp_status <= cmd.code;
            EM_RES_OK: begin
               rsp_gate       <= g_ext[2:0];
               rsp_start_slot <= s_ff[5:0];
               rsp_end_slot   <= e_ff[5:0];
            end
            EM_LK_OK: begin
               rsp_gate       <= g_ext[2:0];
               rsp_start_slot <= i_ff[5:0];
               rsp_end_slot   <= rd_last;
            end
            EM_SLOT: begin
               rsp_gate       <= g_ext[2:0];
               rsp_slot_index <= i_ff[5:0];
               rsp_occupied   <= rd_occ;
               rsp_owner      <= rd_occ ? rd_owner : 16'd0;
               rsp_last       <= (i_ff == e_ff);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit != EM_NONE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");
   a_write_gate: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_RES_WRITE) |-> (8'(g_ff) < ng8))
      else $error("booking written beyond gates in use");
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_RES_WRITE) |-> (i_ff <= e_ff && e_ff < 7'(SLOTS_PER_GATE)))
      else $error("booking write outside its run");
`endif

endmodule

// File: dv/gsrt_checker.sv
// checker for the gate slot reservation table: predicts results and compares them
`timescale 1ns / 1ps
module gsrt_checker
   import gsrt_pkg::*;
#(
   parameter int MAX_GATES      = GATES_DEFAULT,
   parameter int SLOTS_PER_GATE = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_target_node,
   input  logic [15:0] req_owner_id,
   input  logic [5:0]  req_first_slot,
   input  logic [5:0]  req_span,
   input  logic [5:0]  req_slack,
   input  logic [2:0]  req_gate_sel,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [2:0]  rsp_gate,
   input  logic [5:0]  rsp_start_slot,
   input  logic [5:0]  rsp_end_slot,
   input  logic [5:0]  rsp_slot_index,
   input  logic        rsp_occupied,
   input  logic [15:0] rsp_owner,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          result_count
);

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  gate;
      logic [5:0]  start_slot;
      logic [5:0]  end_slot;
      logic [5:0]  slot_index;
      logic        occupied;
      logic [15:0] owner;
      logic        last;
   } booking_result_t;

   logic        busy_q  [MAX_GATES][SLOTS_PER_GATE];
   logic [15:0] holder_q[MAX_GATES][SLOTS_PER_GATE];
   logic [5:0]  bfirst_q[MAX_GATES][SLOTS_PER_GATE];
   logic [5:0]  blast_q [MAX_GATES][SLOTS_PER_GATE];
   logic [3:0]  gates_cfg;
   logic [7:0]  node_cfg;
   booking_result_t awaited[$];

   assign pending = awaited.size();

   function automatic booking_result_t mk(logic [2:0] st, int g, int s, int e);
      booking_result_t r;
      r = '0;
      r.status = st; r.gate = g[2:0]; r.start_slot = s[5:0]; r.end_slot = e[5:0];
      r.last = 1'b1;
      return r;
   endfunction

   // works out and queues the results of one request, updating the table copy
   task automatic predict_booking(logic [1:0] act, logic [7:0] tn, logic [15:0] own,
                                  int first, int span, int slack, int gsel);
      int ng, e, s;
      int i;
      bit done, free;
      booking_result_t r;
      ng = (int'(gates_cfg) > MAX_GATES) ? MAX_GATES : int'(gates_cfg);
      done = 0;
      if (act == ACT_NONE) return;
      if (tn != node_cfg) begin
         awaited.push_back(mk(ST_WRONG_NODE, 0, 0, 0));
      end else if (act == ACT_RESERVE) begin
         if (first >= SLOTS_PER_GATE) awaited.push_back(mk(ST_BAD_START, 0, 0, 0));
         else if (first + span > SLOTS_PER_GATE) awaited.push_back(mk(ST_BAD_SPAN, 0, 0, 0));
         else begin
            for (int g = 0; g < ng && !done; g++) begin
               e = first + span;
               for (s = first; s <= first + slack && e < SLOTS_PER_GATE && !done; s++) begin
                  free = 1;
                  for (i = s; i <= e; i++) if (busy_q[g][i]) free = 0;
                  if (free) begin
                     for (i = s; i <= e; i++) begin
                        busy_q[g][i] = 1; holder_q[g][i] = own;
                        bfirst_q[g][i] = 6'(s); blast_q[g][i] = 6'(e);
                     end
                     awaited.push_back(mk(ST_OK, g, s, e));
                     done = 1;
                  end
                  e++;
               end
            end
            if (!done) awaited.push_back(mk(ST_MISS, 0, 0, 0));
         end
      end else if (act == ACT_LOOKUP) begin
         for (int g = 0; g < ng && !done; g++) begin
            i = 0;
            while (i < SLOTS_PER_GATE && !done) begin
               if (!busy_q[g][i]) i++;
               else if (holder_q[g][i] == own) begin
                  awaited.push_back(mk(ST_OK, g, i, int'(blast_q[g][i])));
                  done = 1;
               end else i = (int'(blast_q[g][i]) + 1 > i) ? int'(blast_q[g][i]) + 1 : i + 1;
            end
         end
         if (!done) awaited.push_back(mk(ST_MISS, 0, 0, 0));
      end else begin
         if (gsel >= ng) awaited.push_back(mk(ST_BAD_GATE, 0, 0, 0));
         else if (first >= SLOTS_PER_GATE) awaited.push_back(mk(ST_BAD_START, 0, 0, 0));
         else if (first + span >= SLOTS_PER_GATE) awaited.push_back(mk(ST_BAD_SPAN, 0, 0, 0));
         else for (i = 0; i <= span; i++) begin
            r = '0;
            r.status = ST_OK; r.gate = gsel[2:0]; r.slot_index = 6'(first + i);
            r.occupied = busy_q[gsel][first + i];
            r.owner = r.occupied ? holder_q[gsel][first + i] : 16'd0;
            r.last = (i == span);
            awaited.push_back(r);
         end
      end
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      booking_result_t exp_r;
      if (reset) begin
         gates_cfg <= GATES_RESET;
         node_cfg  <= NODE_RESET;
         fail_count = 0;
         result_count = 0;
         awaited.delete();
         for (int g = 0; g < MAX_GATES; g++)
            for (int i = 0; i < SLOTS_PER_GATE; i++) begin
               busy_q[g][i] = 0; holder_q[g][i] = 0; bfirst_q[g][i] = 0; blast_q[g][i] = 0;
            end
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (awaited.size() == 0) begin
               $error("unexpected result item, status %0d", rsp_status);
               fail_count++;
            end else begin
               exp_r = awaited.pop_front();
               check_field("status", exp_r.status, rsp_status);
               check_field("gate", exp_r.gate, rsp_gate);
               check_field("start_slot", exp_r.start_slot, rsp_start_slot);
               check_field("end_slot", exp_r.end_slot, rsp_end_slot);
               check_field("slot_index", exp_r.slot_index, rsp_slot_index);
               check_field("occupied", exp_r.occupied, rsp_occupied);
               check_field("owner", exp_r.owner, rsp_owner);
               check_field("last", exp_r.last, rsp_last);
            end
         end
         if (req_valid && req_ready)
            predict_booking(req_action, req_target_node, req_owner_id, req_first_slot,
                            req_span, req_slack, req_gate_sel);
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_GATES) gates_cfg <= csr_data[3:0];
            else node_cfg <= csr_data;
         end
      end
   end

endmodule

// File: dv/testbench.sv
// top of the reservation table testbench: stimulus, register phases and verdict
`timescale 1ns / 1ps
module testbench;
   import gsrt_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_target_node = '0;
   logic [15:0] req_owner_id = '0;
   logic [5:0]  req_first_slot = '0;
   logic [5:0]  req_span = '0;
   logic [5:0]  req_slack = '0;
   logic [2:0]  req_gate_sel = '0;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [7:0]  csr_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status, rsp_gate;
   logic [5:0]  rsp_start_slot, rsp_end_slot, rsp_slot_index;
   logic        rsp_occupied, rsp_last;
   logic [15:0] rsp_owner;
   int          fail_count, pending, result_count;

   // idling percentages, changed per phase
   int send_gap_pct = 0;
   int recv_stall_pct = 0;

   // shadow of node id so that most requests address the right table
   logic [7:0] node_now = NODE_RESET;
   int         items_sent = 0;

   always #1 clock = ~clock;

   gate_slot_reservation_table_core dut (.*);

   gsrt_checker checker_i (.*);

   // receiver: random stalls
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // one request item, held until taken
   task automatic send_booking(logic [1:0] act, logic [7:0] tn, logic [15:0] own,
                               logic [5:0] first, logic [5:0] span, logic [5:0] slack,
                               logic [2:0] gsel);
      do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      req_valid <= 1; req_action <= act; req_target_node <= tn; req_owner_id <= own;
      req_first_slot <= first; req_span <= span; req_slack <= slack; req_gate_sel <= gsel;
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      items_sent++;
   endtask

   // registers written only once the table has settled
   task automatic write_reg(logic idx, logic [7:0] value);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // a dropped action may still be in flight
      repeat (20) @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == REG_NODE) node_now = value;
   endtask

   // random request: mostly well-formed, some noise
   task automatic random_booking();
      int k;
      logic [1:0] act;
      logic [7:0] tn;
      logic [5:0] first, span;
      k = $urandom_range(99);
      act = (k < 45) ? ACT_RESERVE : (k < 70) ? ACT_LOOKUP : (k < 95) ? ACT_STATUS : ACT_NONE;
      tn = ($urandom_range(9) == 0) ? 8'($urandom) : node_now;
      if ($urandom_range(9) == 0) begin
         first = 6'($urandom); span = 6'($urandom);
      end else begin
         first = 6'($urandom_range(SLOTS - 1));
         span = 6'((act == ACT_STATUS) ? $urandom_range(7) : $urandom_range(5));
         if (int'(first) + int'(span) >= SLOTS) first = 6'(SLOTS - 1 - int'(span));
      end
      send_booking(act, tn, 16'($urandom_range(15) == 0 ? $urandom : $urandom_range(12)),
                   first, span, 6'($urandom), 3'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: field extremes, every action, each error path but a bad gate
      send_booking(ACT_RESERVE, 8'd0, 16'hFFFF, 6'd0, 6'd0, 6'd0, 3'd0);
      send_booking(ACT_RESERVE, 8'd0, 16'h0000, 6'd0, 6'd3, 6'd63, 3'd7);
      send_booking(ACT_RESERVE, 8'd0, 16'h1234, 6'd44, 6'd3, 6'd0, 3'd0);   // ends on last slot
      send_booking(ACT_RESERVE, 8'd0, 16'h0007, 6'd40, 6'd8, 6'd5, 3'd0);   // touches edge: miss
      send_booking(ACT_RESERVE, 8'd0, 16'h0007, 6'd40, 6'd9, 6'd5, 3'd0);   // span too long
      send_booking(ACT_RESERVE, 8'd0, 16'h0007, 6'd48, 6'd0, 6'd0, 3'd0);   // start out of range
      send_booking(ACT_RESERVE, 8'd0, 16'h0007, 6'd63, 6'd63, 6'd63, 3'd0);
      send_booking(ACT_RESERVE, 8'hFF, 16'h0007, 6'd0, 6'd0, 6'd0, 3'd0);   // wrong node
      send_booking(ACT_RESERVE, 8'd0, 16'h0055, 6'd0, 6'd47, 6'd0, 3'd0);   // whole gate
      send_booking(ACT_LOOKUP, 8'd0, 16'h1234, 6'd0, 6'd0, 6'd0, 3'd0);
      send_booking(ACT_LOOKUP, 8'd0, 16'h0055, 6'd63, 6'd63, 6'd63, 3'd7);
      send_booking(ACT_LOOKUP, 8'd0, 16'hBEEF, 6'd0, 6'd0, 6'd0, 3'd0);     // miss
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd0, 6'd47, 6'd0, 3'd0);      // full-row report
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd44, 6'd3, 6'd0, 3'd0);
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd44, 6'd4, 6'd0, 3'd0);      // span too long
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd48, 6'd0, 6'd0, 3'd1);      // bad start
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd0, 6'd0, 6'd63, 3'd7);
      send_booking(ACT_NONE, 8'd0, 16'hFFFF, 6'd63, 6'd63, 6'd63, 3'd7);   // dropped
      send_booking(ACT_LOOKUP, 8'h01, 16'h0, 6'd0, 6'd0, 6'd0, 3'd0);

      // fewer gates: gate checks and search limits
      write_reg(REG_GATES, 8'd1);
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd0, 6'd0, 6'd0, 3'd1);       // bad gate
      send_booking(ACT_RESERVE, 8'd0, 16'h0009, 6'd0, 6'd1, 6'd63, 3'd0);  // fits in gate 0 at slots 5 to 6
      write_reg(REG_GATES, 8'd0);
      send_booking(ACT_STATUS, 8'd0, 16'h0, 6'd0, 6'd0, 6'd0, 3'd0);
      send_booking(ACT_LOOKUP, 8'd0, 16'h1234, 6'd0, 6'd0, 6'd0, 3'd0);
      write_reg(REG_GATES, 8'd15);                                          // clamped
      write_reg(REG_NODE, 8'd255);

      // random phases with different idling and settings
      for (int p = 0; p < 4; p++) begin
         send_gap_pct   = (p == 1 || p == 3) ? ((p == 3) ? 14 : 53) : 0;
         recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 14 : 53) : 0;
         if (p == 1) write_reg(REG_NODE, 8'h5A);
         if (p == 2) write_reg(REG_GATES, 8'd3);
         if (p == 3) begin write_reg(REG_GATES, 8'd8); write_reg(REG_NODE, 8'd0); end
         for (int n = 0; n < 50; n++) random_booking();
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("run covered %0d request items and %0d result items over four idling phases",
               items_sent, result_count);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/gsrt_pkg.sv
rtl/core/gsrt_ctrl.sv
rtl/core/gsrt_dp.sv
rtl/core/gate_slot_reservation_table_core.sv
dv/gsrt_checker.sv
dv/testbench.sv
